@@ rtl/rrq_pkg.sv @@
// ============================================================================
// rrq_pkg: shared types and codes for the round-robin run queue
// Command, status and outcome codes, field widths, and the command and
// status bundles that run between the controller and the datapath.
// ============================================================================
`default_nettype none

package rrq_pkg;

  // Default number of queue slots
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 16;
  localparam int ST_W   = 2;
  localparam int OC_W   = 3;
  localparam int QCNT_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ROTATE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RTR       = 3'd3;  // rotate to next ready
  localparam logic [CMD_W-1:0] CMD_FIND_LIVE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND_TERM = 3'd5;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd6;

  // Thread status codes
  localparam logic [ST_W-1:0] ST_BLOCKED    = 2'd2;
  localparam logic [ST_W-1:0] ST_TERMINATED = 2'd3;

  // Outcome codes
  localparam logic [OC_W-1:0] OC_OK       = 3'd0;
  localparam logic [OC_W-1:0] OC_EMPTY    = 3'd1;
  localparam logic [OC_W-1:0] OC_FULL     = 3'd2;
  localparam logic [OC_W-1:0] OC_NORUN    = 3'd3;
  localparam logic [OC_W-1:0] OC_NOTFOUND = 3'd4;

  // Where the result id/status come from
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_INPUT,
    SRC_READ
  } src_t;

  // Queue update that goes with the result load
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PUSH,
    ACT_POP
  } act_t;

  // Controller -> datapath
  typedef struct packed {
    logic            in_load;   // latch the accepted transaction
    logic            off_clr;   // scan offset to zero
    logic            off_inc;
    logic            off_dec;
    logic            head_inc;  // rotate: advance head
    logic            rot_wr;    // rotate: copy head entry to tail
    logic            res_load;  // load the output register
    src_t            src;
    act_t            act;
    logic [OC_W-1:0] outcome;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic last;      // read data is the last counted entry
    logic id_match;  // read id equals the search key
    logic is_term;   // read status is terminated
    logic runnable;  // read status is running or ready
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/rrq_datapath.sv @@
// ============================================================================
// rrq_datapath: entry store, head/count pointers and output register
// Holds the circular entry store with one registered read port and one
// write port, the scan offset, the latched transaction and the result.
// ============================================================================
`default_nettype none

module rrq_datapath #(
  parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rrq_pkg::ID_W-1:0]      thread_id,
  input  logic [rrq_pkg::ST_W-1:0]      thread_status,
  input  rrq_pkg::dp_cmd_t              dp_cmd,
  output rrq_pkg::dp_stat_t             dp_stat,
  output logic [rrq_pkg::OC_W-1:0]      outcome,
  output logic [rrq_pkg::ID_W-1:0]      result_id,
  output logic [rrq_pkg::ST_W-1:0]      result_status,
  output logic [rrq_pkg::QCNT_W-1:0]    queue_count
);
  import rrq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

  // Entry store
  logic [ID_W-1:0] mem_id [QUEUE_DEPTH];
  logic [ST_W-1:0] mem_st [QUEUE_DEPTH];

  logic [IDX_W-1:0]       head;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       off;
  logic [ID_W-1:0]        key_id;
  logic [ST_W-1:0]        key_st;
  logic [ID_W-1:0]        rd_id;
  logic [ST_W-1:0]        rd_st;

  logic [SUM_W-1:0]       rd_sum;
  logic [SUM_W-1:0]       tail_sum;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       tail_addr;
  logic [IDX_W-1:0]       head_next;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W+QCNT_W-1:0] count_ext;
  logic                   push_now;
  logic                   pop_now;

  // Slot addresses, wrapped with one compare and subtract
  assign rd_sum    = SUM_W'(head) + SUM_W'(off);
  assign tail_sum  = SUM_W'(head) + SUM_W'(count);
  assign rd_addr   = (rd_sum >= DEPTH_SUM) ? IDX_W'(rd_sum - DEPTH_SUM) : IDX_W'(rd_sum);
  assign tail_addr = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                             : IDX_W'(tail_sum);

  assign push_now = dp_cmd.res_load && (dp_cmd.act == ACT_PUSH);
  assign pop_now  = dp_cmd.res_load && (dp_cmd.act == ACT_POP);

  assign head_next = (head == LAST_IDX) ? '0 : head + IDX_W'(1);

  always_comb begin
    if (push_now) begin
      count_next = count + CNT_W'(1);
    end else if (pop_now) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  assign count_ext = {{QCNT_W{1'b0}}, count_next};

  // Status toward the controller
  assign dp_stat.empty    = (count == '0);
  assign dp_stat.full     = (count == DEPTH_CNT);
  assign dp_stat.last     = (off == count);
  assign dp_stat.id_match = (rd_id == key_id);
  assign dp_stat.is_term  = (rd_st == ST_TERMINATED);
  assign dp_stat.runnable = (rd_st != ST_BLOCKED) && (rd_st != ST_TERMINATED);

  // Pointers and scan offset
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      off   <= '0;
    end else begin
      if (pop_now || dp_cmd.head_inc) begin
        head <= head_next;
      end
      count <= count_next;
      if (dp_cmd.off_clr) begin
        off <= '0;
      end else if (dp_cmd.off_dec) begin
        off <= off - CNT_W'(1);
      end else if (dp_cmd.off_inc) begin
        off <= off + CNT_W'(1);
      end
    end
  end

  // Store: write at the tail, registered read at head + offset
  always_ff @(posedge clk) begin
    if (push_now) begin
      mem_id[tail_addr] <= key_id;
      mem_st[tail_addr] <= key_st;
    end else if (dp_cmd.rot_wr) begin
      mem_id[tail_addr] <= rd_id;
      mem_st[tail_addr] <= rd_st;
    end
    rd_id <= mem_id[rd_addr];
    rd_st <= mem_st[rd_addr];
  end

  // Latched transaction and output register
  always_ff @(posedge clk) begin
    if (dp_cmd.in_load) begin
      key_id <= thread_id;
      key_st <= thread_status;
    end
    if (dp_cmd.res_load) begin
      outcome     <= dp_cmd.outcome;
      queue_count <= count_ext[QCNT_W-1:0];
      case (dp_cmd.src)
        SRC_INPUT: begin
          result_id     <= key_id;
          result_status <= key_st;
        end
        SRC_READ: begin
          result_id     <= rd_id;
          result_status <= rd_st;
        end
        default: begin
          result_id     <= '0;
          result_status <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/rrq_ctrl.sv @@
// ============================================================================
// rrq_ctrl: run queue sequencer
// Decodes each transaction, steps the scans and rotations, and loads the
// output register once it is free.
// ============================================================================
`default_nettype none

module rrq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rrq_pkg::CMD_W-1:0] cmd,
  input  logic                      out_ready,
  output logic                      out_valid,
  output rrq_pkg::dp_cmd_t          dp_cmd,
  input  rrq_pkg::dp_stat_t         dp_stat
);
  import rrq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_RTR_WAIT,
    S_RTR_STEP,
    S_FINISH
  } state_t;

  state_t          state, state_next;
  logic [CMD_W-1:0] op, op_next;
  logic            rot_first, rot_first_next;
  logic [OC_W-1:0] fin_oc, fin_oc_next;
  src_t            fin_src, fin_src_next;
  act_t            fin_act, fin_act_next;
  logic            out_valid_next;
  logic            out_free;
  logic            find_hit;
  logic            scan_hit;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Match test for the scan, by operation
  assign find_hit = dp_stat.id_match &&
                    ((op == CMD_FIND_TERM) ? dp_stat.is_term : !dp_stat.is_term);
  assign scan_hit = (op == CMD_RTR) ? dp_stat.runnable : find_hit;

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    op_next        = op;
    rot_first_next = rot_first;
    fin_oc_next    = fin_oc;
    fin_src_next   = fin_src;
    fin_act_next   = fin_act;
    dp_cmd         = '0;
    dp_cmd.src     = SRC_ZERO;
    dp_cmd.act     = ACT_NONE;
    dp_cmd.outcome = OC_OK;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.in_load = 1'b1;
          op_next        = cmd;
          fin_oc_next    = OC_OK;
          fin_src_next   = SRC_ZERO;
          fin_act_next   = ACT_NONE;
          state_next     = S_FINISH;
          case (cmd)
            CMD_PUSH: begin
              if (dp_stat.full) begin
                fin_oc_next = OC_FULL;
              end else begin
                fin_src_next = SRC_INPUT;
                fin_act_next = ACT_PUSH;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (dp_stat.empty) begin
                fin_oc_next = OC_EMPTY;
              end else begin
                fin_src_next = SRC_READ;
                fin_act_next = (cmd == CMD_POP) ? ACT_POP : ACT_NONE;
              end
            end
            CMD_ROTATE: begin
              if (dp_stat.empty) begin
                fin_oc_next = OC_EMPTY;
              end else begin
                rot_first_next = 1'b1;
                state_next     = S_RTR_WAIT;
              end
            end
            CMD_RTR: begin
              if (dp_stat.empty) begin
                fin_oc_next = OC_EMPTY;
              end else begin
                dp_cmd.off_inc = 1'b1;
                state_next     = S_SCAN;
              end
            end
            CMD_FIND_LIVE, CMD_FIND_TERM: begin
              if (dp_stat.empty) begin
                fin_oc_next = OC_NOTFOUND;
              end else begin
                dp_cmd.off_inc = 1'b1;
                state_next     = S_SCAN;
              end
            end
            default: begin
              // no-op code: plain ok result
            end
          endcase
        end else begin
          dp_cmd.off_clr = 1'b1;
        end
      end

      // One entry per cycle; the read data is registered and belongs to the previous offset
      S_SCAN: begin
        if (scan_hit) begin
          if (op == CMD_RTR) begin
            dp_cmd.off_clr = 1'b1;
            rot_first_next = 1'b1;
            state_next     = S_RTR_WAIT;
          end else begin
            dp_cmd.off_dec = 1'b1;
            fin_oc_next    = OC_OK;
            fin_src_next   = SRC_READ;
            fin_act_next   = ACT_NONE;
            state_next     = S_SETTLE;
          end
        end else if (dp_stat.last) begin
          fin_oc_next  = (op == CMD_RTR) ? OC_NORUN : OC_NOTFOUND;
          fin_src_next = SRC_ZERO;
          fin_act_next = ACT_NONE;
          state_next   = S_FINISH;
        end else begin
          dp_cmd.off_inc = 1'b1;
        end
      end

      S_SETTLE: begin
        state_next = S_FINISH;
      end

      S_RTR_WAIT: begin
        state_next = S_RTR_STEP;
      end

      // Read data is the head entry here
      S_RTR_STEP: begin
        if (rot_first || (op == CMD_RTR && !dp_stat.runnable)) begin
          dp_cmd.rot_wr   = 1'b1;
          dp_cmd.head_inc = 1'b1;
          rot_first_next  = 1'b0;
          state_next      = S_RTR_WAIT;
        end else begin
          fin_oc_next  = OC_OK;
          fin_src_next = SRC_READ;
          fin_act_next = ACT_NONE;
          state_next   = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          dp_cmd.res_load = 1'b1;
          dp_cmd.off_clr  = 1'b1;
          dp_cmd.outcome  = fin_oc;
          dp_cmd.src      = fin_src;
          dp_cmd.act      = fin_act;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (dp_cmd.res_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rot_first <= 1'b0;
      op        <= '0;
      fin_oc    <= OC_OK;
      fin_src   <= SRC_ZERO;
      fin_act   <= ACT_NONE;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      rot_first <= rot_first_next;
      op        <= op_next;
      fin_oc    <= fin_oc_next;
      fin_src   <= fin_src_next;
      fin_act   <= fin_act_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/round_robin_run_queue.sv @@
// ============================================================================
// round_robin_run_queue: bounded round-robin run queue of thread entries
// Push, pop, peek, rotate, rotate to next ready, and id searches over a
// circular store of thread id / status entries.
// ============================================================================
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | cmd, thread_id, thread_status
//  out     | out_valid / out_ready| outcome, result_id, result_status,
//          |                      | queue_count
//
//  One transaction at a time; the output register holds a finished result
//  while the next transaction is taken. Searches step one entry per cycle
//  through the store's read port. Reset clears head, count and the scan
//  offset; the store needs no clearing pass. A stalled output holds the
//  sequencer in its final state until taken.
//
`default_nettype none

module round_robin_run_queue #(
  parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rrq_pkg::CMD_W-1:0]  cmd,
  input  logic [rrq_pkg::ID_W-1:0]   thread_id,
  input  logic [rrq_pkg::ST_W-1:0]   thread_status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rrq_pkg::OC_W-1:0]   outcome,
  output logic [rrq_pkg::ID_W-1:0]   result_id,
  output logic [rrq_pkg::ST_W-1:0]   result_status,
  output logic [rrq_pkg::QCNT_W-1:0] queue_count
);
  import rrq_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer
  rrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  // Store, pointers and result register
  rrq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .thread_id     (thread_id),
    .thread_status (thread_status),
    .dp_cmd        (dp_cmd),
    .dp_stat       (dp_stat),
    .outcome       (outcome),
    .result_id     (result_id),
    .result_status (result_status),
    .queue_count   (queue_count)
  );

endmodule

`default_nettype wire

@@ rtl/rrq_checker.sv @@
// ============================================================================
// rrq_checker: port-level checks for the run queue
// Watches the result channel for consistent outcomes and stable stalls.
// ============================================================================
`default_nettype none

module rrq_checker #(
  parameter int QUEUE_DEPTH = rrq_pkg::QUEUE_DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rrq_pkg::OC_W-1:0]   outcome,
  input logic [rrq_pkg::ID_W-1:0]   result_id,
  input logic [rrq_pkg::ST_W-1:0]   result_status,
  input logic [rrq_pkg::QCNT_W-1:0] queue_count
);
  import rrq_pkg::*;

  localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH % 32);

  // Error outcomes carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OC_EMPTY || outcome == OC_FULL ||
                  outcome == OC_NORUN || outcome == OC_NOTFOUND)
    |-> (result_id == '0) && (result_status == '0))
    else $error("error outcome with nonzero entry fields");

  // Empty means nothing held, full means every slot held
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OC_EMPTY) |-> (queue_count == '0))
    else $error("empty outcome with nonzero count");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == OC_FULL) |-> (queue_count == FULL_CNT))
    else $error("full outcome with count below depth");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) &&
                                $stable(result_id) && $stable(queue_count))
    else $error("result changed while stalled");

endmodule

bind round_robin_run_queue rrq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rrq_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .outcome       (outcome),
  .result_id     (result_id),
  .result_status (result_status),
  .queue_count   (queue_count)
);

`default_nettype wire

@@ sim/tb.sv @@
// ============================================================================
// tb: self-checking testbench for round_robin_run_queue
// Drives push, pop, rotate, rotate-to-ready, find and peek transactions over
// a valid/ready channel. A local queue model predicts every result, and a
// monitor compares each output transaction field by field, in order.
// ============================================================================
`default_nettype none

module tb;
  import rrq_pkg::*;

  localparam int QD = QUEUE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 100;

  // Codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_NOP    = 3'd7;
  localparam logic [ST_W-1:0]  ST_RUNNING = 2'd0;
  localparam logic [ST_W-1:0]  ST_READY   = 2'd1;

  typedef struct packed {
    logic [OC_W-1:0]   oc;
    logic [ID_W-1:0]   id;
    logic [ST_W-1:0]   st;
    logic [QCNT_W-1:0] cnt;
  } run_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  cmd = CMD_NOP;
  logic [ID_W-1:0]   thread_id = '0;
  logic [ST_W-1:0]   thread_status = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OC_W-1:0]   outcome;
  logic [ID_W-1:0]   result_id;
  logic [ST_W-1:0]   result_status;
  logic [QCNT_W-1:0] queue_count;

  // Long receiver hold-off request, raised by the backpressure test
  logic hold_req = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;

  // Model of the run queue
  logic [ID_W-1:0] slot_id [QD];
  logic [ST_W-1:0] slot_st [QD];
  int              run_head = 0;
  int              run_count = 0;

  run_result_t pending_results [$];

  round_robin_run_queue dut (.*);

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Queue model
  // ---------------------------------------------------------------------------
  function automatic int slot_of(int off);
    return (run_head + off) % QD;
  endfunction

  function automatic bit is_runnable(logic [ST_W-1:0] st);
    return st != ST_BLOCKED && st != ST_TERMINATED;
  endfunction

  // Head entry copied behind the tail, head advances
  function automatic void rotate_head();
    int dst;
    dst = slot_of(run_count);
    slot_id[dst] = slot_id[run_head];
    slot_st[dst] = slot_st[run_head];
    run_head = slot_of(1);
  endfunction

  function automatic run_result_t apply_sched_op(logic [CMD_W-1:0] op, logic [ID_W-1:0] key,
                                                 logic [ST_W-1:0] st);
    run_result_t res;
    int k;
    int slot;
    bit any_run;
    res = '0;
    case (op)
      CMD_PUSH: begin
        if (run_count >= QD) begin
          res.oc = OC_FULL;
        end else begin
          slot = slot_of(run_count);
          slot_id[slot] = key;
          slot_st[slot] = st;
          run_count++;
          res.id = key;
          res.st = st;
        end
      end
      CMD_POP: begin
        if (run_count == 0) begin
          res.oc = OC_EMPTY;
        end else begin
          res.id = slot_id[run_head];
          res.st = slot_st[run_head];
          run_head = slot_of(1);
          run_count--;
        end
      end
      CMD_ROTATE, CMD_RTR, CMD_PEEK: begin
        if (run_count == 0) begin
          res.oc = OC_EMPTY;
        end else begin
          any_run = 1'b1;
          if (op == CMD_ROTATE) begin
            rotate_head();
          end else if (op == CMD_RTR) begin
            any_run = 1'b0;
            for (k = 0; k < run_count; k++)
              if (is_runnable(slot_st[slot_of(k)])) any_run = 1'b1;
            // at least one rotation, then on until the head can run
            if (any_run) begin
              do rotate_head(); while (!is_runnable(slot_st[run_head]));
            end
          end
          if (any_run) begin
            res.id = slot_id[run_head];
            res.st = slot_st[run_head];
          end else begin
            res.oc = OC_NORUN;
          end
        end
      end
      CMD_FIND_LIVE, CMD_FIND_TERM: begin
        res.oc = OC_NOTFOUND;
        for (k = 0; k < run_count; k++) begin
          slot = slot_of(k);
          if (res.oc == OC_NOTFOUND && slot_id[slot] == key &&
              ((slot_st[slot] == ST_TERMINATED) == (op == CMD_FIND_TERM))) begin
            res.oc = OC_OK;
            res.id = slot_id[slot];
            res.st = slot_st[slot];
          end
        end
      end
      default: ;
    endcase
    res.cnt = QCNT_W'(run_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transaction, with random idle cycles ahead of it
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] key,
                         input logic [ST_W-1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= op;
    thread_id     <= key;
    thread_status <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_sched_op(op, key, st));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (!hold_req) hold_taken = 1'b0;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    run_result_t got;
    run_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{outcome, result_id, result_status, queue_count};
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: oc=%0d id=%h st=%0d cnt=%0d",
                   got.oc, got.id, got.st, got.cnt);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10)
            $display("result mismatch: expected oc=%0d id=%h st=%0d cnt=%0d, got oc=%0d id=%h st=%0d cnt=%0d",
                     want.oc, want.id, want.st, want.cnt, got.oc, got.id, got.st, got.cnt);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pop, peek, rotate, rotate-to-ready and live search on an empty queue
  task automatic test_empty_queue();
    send_op(CMD_POP, 16'h0000, ST_RUNNING);
    send_op(CMD_PEEK, 16'hFFFF, ST_TERMINATED);
    send_op(CMD_ROTATE, 16'h5555, ST_READY);
    send_op(CMD_RTR, 16'hAAAA, ST_BLOCKED);
    send_op(CMD_FIND_LIVE, 16'h0000, ST_RUNNING);
  endtask

  // Fill to capacity with mostly unrunnable entries, then one refused push
  task automatic test_fill_and_refuse();
    int i;
    logic [ST_W-1:0] st;
    for (i = 0; i < QD; i++) begin
      if (i == 0) st = ST_RUNNING;
      else if (i == 11) st = ST_READY;
      else st = (i % 2) ? ST_TERMINATED : ST_BLOCKED;
      send_op(CMD_PUSH, ID_W'(16'h1111 * i), st);
    end
    send_op(CMD_PUSH, 16'hFFFF, ST_READY);
  endtask

  // Rotations and searches on a full queue
  task automatic test_full_scans();
    send_op(CMD_RTR, 16'h0000, ST_RUNNING);
    send_op(CMD_ROTATE, 16'h0000, ST_RUNNING);
    send_op(CMD_FIND_LIVE, 16'hBBBB, ST_RUNNING);
    send_op(CMD_FIND_TERM, 16'hFFFF, ST_RUNNING);
    send_op(CMD_FIND_LIVE, 16'hFFFF, ST_RUNNING);
  endtask

  // Receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    int i;
    hold_req <= 1'b1;
    for (i = 0; i < QD + 2; i++) send_op(CMD_POP, ID_W'($urandom), ST_W'($urandom));
    send_op(CMD_PUSH, 16'h8001, ST_BLOCKED);
    send_op(CMD_PUSH, 16'h7FFE, ST_TERMINATED);
    send_op(CMD_PUSH, 16'h8001, ST_TERMINATED);
    // nothing runnable
    send_op(CMD_RTR, 16'h0000, ST_READY);
    send_op(CMD_FIND_LIVE, 16'h8001, ST_RUNNING);
    send_op(CMD_FIND_TERM, 16'h8001, ST_RUNNING);
    send_op(CMD_FIND_LIVE, 16'h7FFE, ST_RUNNING);
    send_op(CMD_PEEK, 16'h0000, ST_RUNNING);
    send_op(CMD_NOP, 16'hFFFF, ST_TERMINATED);
    hold_req <= 1'b0;
  endtask

  // Random traffic that swings the fill level between empty and full
  task automatic test_random_traffic(input int n, input int s_pct, input int r_pct);
    int i;
    int r;
    int w_push;
    int w_pop;
    bit filling;
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  key;
    logic [ST_W-1:0]  st;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    filling = 1'b1;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0) filling = ~filling;
      w_push = filling ? 40 : 12;
      w_pop  = filling ? 12 : 40;
      r = $urandom_range(w_push + w_pop + 54);
      if (r < w_push) begin
        op = CMD_PUSH;
      end else if (r < w_push + w_pop) begin
        op = CMD_POP;
      end else begin
        r -= w_push + w_pop;
        if (r < 10) op = CMD_ROTATE;
        else if (r < 22) op = CMD_RTR;
        else if (r < 34) op = CMD_FIND_LIVE;
        else if (r < 44) op = CMD_FIND_TERM;
        else if (r < 52) op = CMD_PEEK;
        else op = CMD_NOP;
      end
      // small ids give duplicates; full-range ids toggle every bit
      key = $urandom_range(1) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
      if ((op == CMD_FIND_LIVE || op == CMD_FIND_TERM) && run_count > 0 &&
          $urandom_range(3) != 0)
        key = slot_id[slot_of($urandom_range(run_count - 1))];
      st = ST_W'($urandom_range(3));
      send_op(op, key, st);
    end
  endtask

  // Wait out all expected results, then report
  task automatic finish_run();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (mismatch_count == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
      $finish;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 35;
    recv_idle_pct = 51;
    test_empty_queue();
    test_fill_and_refuse();
    test_full_scans();
    test_backpressure();
    test_random_traffic(500, 35, 51);
    test_random_traffic(500, 51, 35);
    test_random_traffic(500, 0, 0);
    finish_run();
  end

endmodule

`default_nettype wire

@@ round_robin_run_queue.f @@
rtl/rrq_pkg.sv
rtl/rrq_datapath.sv
rtl/rrq_ctrl.sv
rtl/round_robin_run_queue.sv
rtl/rrq_checker.sv
sim/tb.sv
